// File: rtl/aisp_pkg.sv
// Package for the AVR serial programming command engine.
// Holds phase codes, operation codes, instruction constants and frame helpers.
// No dependencies.
package aisp_pkg;

   localparam int EepromPageBytes = 4;
   localparam logic [2:0] FlashPageLog2Reset = 3'd5;
   localparam int EeRecipShift = 22;

   // Sequencer phases, one-hot.
   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_PRE_EN  = 7'b0000010,
      PH_MAIN    = 7'b0000100,
      PH_MAIN2   = 7'b0001000,
      PH_PAGE    = 7'b0010000,
      PH_POLL_EN = 7'b0100000,
      PH_POLL    = 7'b1000000
   } phase_type;

   // Operation codes.
   localparam logic [3:0] OP_ENABLE    = 4'd0;
   localparam logic [3:0] OP_SIGNATURE = 4'd1;
   localparam logic [3:0] OP_LOCK_RD   = 4'd2;
   localparam logic [3:0] OP_FUSE_RD   = 4'd3;
   localparam logic [3:0] OP_FUSEH_RD  = 4'd4;
   localparam logic [3:0] OP_FUSEX_RD  = 4'd5;
   localparam logic [3:0] OP_CALIB_RD  = 4'd6;
   localparam logic [3:0] OP_FLASH_RD  = 4'd7;
   localparam logic [3:0] OP_EEPROM_RD = 4'd8;
   localparam logic [3:0] OP_ERASE     = 4'd9;
   localparam logic [3:0] OP_LOCK_WR   = 4'd10;
   localparam logic [3:0] OP_FUSE_WR   = 4'd11;
   localparam logic [3:0] OP_FUSEH_WR  = 4'd12;
   localparam logic [3:0] OP_FUSEX_WR  = 4'd13;
   localparam logic [3:0] OP_FLASH_LD  = 4'd14;
   localparam logic [3:0] OP_EEPROM_LD = 4'd15;

   // Completion status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_LINK_ERR  = 2'd1;
   localparam logic [1:0] ST_NO_ECHO   = 2'd2;

   // Instruction bytes.
   localparam logic [7:0] CMD_PROG_EN  = 8'hAC;
   localparam logic [7:0] CMD_ECHO     = 8'h53;
   localparam logic [7:0] CMD_POLL     = 8'hF0;
   localparam logic [7:0] CMD_SIG      = 8'h30;
   localparam logic [7:0] CMD_RD_LOCK  = 8'h58;
   localparam logic [7:0] CMD_RD_FUSE  = 8'h50;
   localparam logic [7:0] CMD_RD_CAL   = 8'h38;
   localparam logic [7:0] CMD_RD_FLL   = 8'h20;
   localparam logic [7:0] CMD_RD_FLH   = 8'h28;
   localparam logic [7:0] CMD_RD_EE    = 8'hA0;
   localparam logic [7:0] CMD_LD_FLL   = 8'h40;
   localparam logic [7:0] CMD_LD_FLH   = 8'h48;
   localparam logic [7:0] CMD_WR_FLPG  = 8'h4C;
   localparam logic [7:0] CMD_LD_EE    = 8'hC1;
   localparam logic [7:0] CMD_WR_EEPG  = 8'hC2;
   localparam logic [7:0] SUB_ERASE    = 8'h80;
   localparam logic [7:0] SUB_WR_LOCK  = 8'hE0;
   localparam logic [7:0] SUB_WR_FUSE  = 8'hA0;
   localparam logic [7:0] SUB_WR_FUSEH = 8'hA8;
   localparam logic [7:0] SUB_WR_FUSEX = 8'hA4;

   // Held command context shared between the sequencer and the frame builder.
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  op;
      logic [15:0] addr;
      logic [15:0] data;
   } frame_ctx_type;

   // Remainder of a by the EEPROM page size n, using the precomputed
   // reciprocal ceil(2^EeRecipShift / n). Exact for a up to 2^16 and n up to 64.
   function automatic logic [6:0] ee_mod(input logic [16:0] a, input logic [22:0] recip,
                                         input logic [6:0] n);
      logic [39:0] prod;
      logic [16:0] quo;
      logic [16:0] rem;
      prod = {23'd0, a} * {17'd0, recip};
      quo  = prod[EeRecipShift +: 17];
      rem  = a - 17'(quo * {10'd0, n});
      return rem[6:0];
   endfunction

endpackage

// File: rtl/aisp_frame.sv
// Frame byte builder: picks one byte of the current four-byte instruction.
// Depends on aisp_pkg.
module aisp_frame #(
   parameter int EEPROM_PAGE_BYTES = aisp_pkg::EepromPageBytes
) (
   input  aisp_pkg::frame_ctx_type ctx,
   input  logic [1:0]              pos,
   output logic [7:0]              tx_byte
);
   localparam int EeW = (EEPROM_PAGE_BYTES > 1) ? $clog2(EEPROM_PAGE_BYTES) : 1;
   localparam logic [22:0] EeRecip =
      23'(((1 << aisp_pkg::EeRecipShift) + EEPROM_PAGE_BYTES - 1) / EEPROM_PAGE_BYTES);
   localparam logic [6:0] EeN = 7'(EEPROM_PAGE_BYTES);

   logic [7:0]  ah, al, dl, dh, ee_off, ee_base;
   logic [6:0]  off7;
   logic [15:0] off16;
   logic [7:0]  f0, f1, f2, f3;
   logic        en_frame;

   // Offset within an EEPROM page, taken by a reciprocal multiply.
   always_comb begin
      off7 = aisp_pkg::ee_mod({1'b0, ctx.addr}, EeRecip, EeN);
      off16 = {9'd0, off7};
      ah = ctx.addr[15:8];
      al = ctx.addr[7:0];
      dl = ctx.data[7:0];
      dh = ctx.data[15:8];
      ee_off = off16[7:0];
      ee_base = 8'(ctx.addr - off16);
   end

   assign en_frame = (ctx.phase == aisp_pkg::PH_PRE_EN) ||
                     (ctx.phase == aisp_pkg::PH_POLL_EN) ||
                     (ctx.phase == aisp_pkg::PH_MAIN && ctx.op == aisp_pkg::OP_ENABLE);

   // Instruction bytes for the current phase and operation.
   always_comb begin
      f0 = 8'h00; f1 = 8'h00; f2 = 8'h00; f3 = 8'h00;
      if (en_frame) begin
         f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::CMD_ECHO;
      end else if (ctx.phase == aisp_pkg::PH_POLL) begin
         f0 = aisp_pkg::CMD_POLL;
      end else if (ctx.phase == aisp_pkg::PH_PAGE) begin
         if (ctx.op == aisp_pkg::OP_FLASH_LD) begin
            f0 = aisp_pkg::CMD_WR_FLPG; f1 = ah; f2 = al;
         end else begin
            f0 = aisp_pkg::CMD_WR_EEPG; f1 = {6'd0, ah[1:0]}; f2 = ee_base;
         end
      end else if (ctx.phase == aisp_pkg::PH_MAIN2) begin
         if (ctx.op == aisp_pkg::OP_FLASH_RD) begin
            f0 = aisp_pkg::CMD_RD_FLH; f1 = ah; f2 = al;
         end else begin
            f0 = aisp_pkg::CMD_LD_FLH; f2 = al; f3 = dh;
         end
      end else begin
         unique case (ctx.op)
            aisp_pkg::OP_ENABLE: begin
               f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::CMD_ECHO;
            end
            aisp_pkg::OP_SIGNATURE: begin f0 = aisp_pkg::CMD_SIG; f2 = al; end
            aisp_pkg::OP_LOCK_RD:   f0 = aisp_pkg::CMD_RD_LOCK;
            aisp_pkg::OP_FUSE_RD:   f0 = aisp_pkg::CMD_RD_FUSE;
            aisp_pkg::OP_FUSEH_RD: begin f0 = aisp_pkg::CMD_RD_LOCK; f1 = 8'h08; end
            aisp_pkg::OP_FUSEX_RD: begin f0 = aisp_pkg::CMD_RD_FUSE; f1 = 8'h08; end
            aisp_pkg::OP_CALIB_RD:  f0 = aisp_pkg::CMD_RD_CAL;
            aisp_pkg::OP_FLASH_RD: begin f0 = aisp_pkg::CMD_RD_FLL; f1 = ah; f2 = al; end
            aisp_pkg::OP_EEPROM_RD: begin
               f0 = aisp_pkg::CMD_RD_EE; f1 = {6'd0, ah[1:0]}; f2 = al;
            end
            aisp_pkg::OP_ERASE: begin f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::SUB_ERASE; end
            aisp_pkg::OP_LOCK_WR: begin
               f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::SUB_WR_LOCK; f3 = dl;
            end
            aisp_pkg::OP_FUSE_WR: begin
               f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::SUB_WR_FUSE; f3 = dl;
            end
            aisp_pkg::OP_FUSEH_WR: begin
               f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::SUB_WR_FUSEH; f3 = dl;
            end
            aisp_pkg::OP_FUSEX_WR: begin
               f0 = aisp_pkg::CMD_PROG_EN; f1 = aisp_pkg::SUB_WR_FUSEX; f3 = dl;
            end
            aisp_pkg::OP_FLASH_LD: begin f0 = aisp_pkg::CMD_LD_FLL; f2 = al; f3 = dl; end
            default: begin
               f0 = aisp_pkg::CMD_LD_EE; f2 = {{(8-EeW){1'b0}}, ee_off[EeW-1:0]}; f3 = dl;
            end
         endcase
      end
   end

   // Byte select by frame position.
   always_comb begin
      unique case (pos)
         2'd0: tx_byte = f0;
         2'd1: tx_byte = f1;
         2'd2: tx_byte = f2;
         default: tx_byte = f3;
      endcase
   end

endmodule

// File: rtl/avr_isp_command_engine_core.sv
// Top level of the AVR serial programming command engine.
// Responses are registered, and one request per cycle is taken while the skid entry
// is empty: the response register plus a skid stage let a new request enter while a
// response waits to be taken.
// Reset (synchronous, active high) returns the sequencer to idle with all held
// state cleared and flash_page_log2 set to 5.
module avr_isp_command_engine_core #(
   parameter int EEPROM_PAGE_BYTES = aisp_pkg::EepromPageBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,      // flash_page_log2
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] operation, [19:4] address, [35:20] write_data, [36] send_enable,
   // [44:37] reply_byte, [45] reply_error, [47:46] zero fill
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,        // action
   input  logic        req_tlast,        // last_in_run
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] tx_byte, [23:8] read_data, [25:24] status, [31:26] zero fill
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser         // kind
);
   localparam logic [22:0] EeRecip =
      23'(((1 << aisp_pkg::EeRecipShift) + EEPROM_PAGE_BYTES - 1) / EEPROM_PAGE_BYTES);
   localparam logic [6:0] EeN = 7'(EEPROM_PAGE_BYTES);

   // Output register and one skid entry.
   logic        out_v_ff, skid_v_ff;
   logic [32:0] out_d_ff, skid_d_ff;
   logic        stage_ok;

   assign stage_ok   = !skid_v_ff;
   assign req_tready = stage_ok;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // Sequencer state.
   aisp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic [3:0]  op_ff, op_in;
   logic [15:0] addr_ff, addr_in, data_ff, data_in;
   logic [7:0]  low_ff, low_in, echo_ff, echo_in;
   logic        due_ff, due_in;
   logic [2:0]  log2_ff;

   logic        a_action, a_en, a_err, a_last;
   logic [3:0]  a_op;
   logic [15:0] a_addr, a_data;
   logic [7:0]  a_reply;
   assign a_action = req_tuser;
   assign a_op     = req_tdata[3:0];
   assign a_addr   = req_tdata[19:4];
   assign a_data   = req_tdata[35:20];
   assign a_en     = req_tdata[36];
   assign a_reply  = req_tdata[44:37];
   assign a_err    = req_tdata[45];
   assign a_last   = req_tlast;

   aisp_pkg::frame_ctx_type ctx;
   logic [7:0] tx_byte;
   aisp_frame #(.EEPROM_PAGE_BYTES(EEPROM_PAGE_BYTES)) u_frame (
      .ctx(ctx), .pos(pos_in), .tx_byte(tx_byte)
   );
   assign ctx = '{phase: phase_in, op: op_in, addr: addr_in, data: data_in};

   logic        r_v, r_kind, r_byte;
   logic [15:0] r_rd;
   logic [1:0]  r_st;
   logic [16:0] mask, ap1;
   logic        en_frame_cur;

   assign en_frame_cur = (phase_ff == aisp_pkg::PH_PRE_EN) ||
                         (phase_ff == aisp_pkg::PH_POLL_EN) ||
                         (phase_ff == aisp_pkg::PH_MAIN && op_ff == aisp_pkg::OP_ENABLE);

   // Next-state and result selection for one accepted transaction.
   always_comb begin
      phase_in = phase_ff; pos_in = pos_ff; op_in = op_ff; addr_in = addr_ff;
      data_in = data_ff; low_in = low_ff; echo_in = echo_ff; due_in = due_ff;
      r_v = 1'b0; r_kind = 1'b0; r_byte = 1'b0; r_rd = 16'd0; r_st = aisp_pkg::ST_OK;
      mask = (17'd1 << log2_ff) - 17'd1;
      ap1 = {1'b0, a_addr} + 17'd1;
      if (acc) begin
         if (!a_action) begin
            if (phase_ff == aisp_pkg::PH_IDLE) begin
               op_in = a_op; addr_in = a_addr; data_in = a_data;
               low_in = 8'd0; echo_in = 8'd0;
               if (a_op == aisp_pkg::OP_FLASH_LD)
                  due_in = a_last || ((ap1 & mask) == 17'd0);
               else if (a_op == aisp_pkg::OP_EEPROM_LD)
                  due_in = a_last || (aisp_pkg::ee_mod(ap1, EeRecip, EeN) == 7'd0);
               else
                  due_in = 1'b0;
               phase_in = (a_en && a_op != aisp_pkg::OP_ENABLE) ?
                          aisp_pkg::PH_PRE_EN : aisp_pkg::PH_MAIN;
               pos_in = 2'd0; r_v = 1'b1; r_byte = 1'b1;
            end
         end else if (phase_ff != aisp_pkg::PH_IDLE) begin
            r_v = 1'b1;
            if (a_err) begin
               r_kind = 1'b1; r_st = aisp_pkg::ST_LINK_ERR;
            end else begin
               if (pos_ff == 2'd2 && en_frame_cur) echo_in = a_reply;
               if (pos_ff != 2'd3) begin
                  pos_in = pos_ff + 2'd1; r_byte = 1'b1;
               end else begin
                  pos_in = 2'd0;
                  unique case (phase_ff)
                     aisp_pkg::PH_PRE_EN:
                        if (echo_ff != aisp_pkg::CMD_ECHO) begin
                           r_kind = 1'b1; r_st = aisp_pkg::ST_NO_ECHO;
                        end else begin phase_in = aisp_pkg::PH_MAIN; r_byte = 1'b1; end
                     aisp_pkg::PH_MAIN:
                        if (op_ff == aisp_pkg::OP_ENABLE) begin
                           r_kind = 1'b1;
                           r_st = (echo_ff == aisp_pkg::CMD_ECHO) ?
                                  aisp_pkg::ST_OK : aisp_pkg::ST_NO_ECHO;
                        end else if (op_ff <= aisp_pkg::OP_CALIB_RD ||
                                     op_ff == aisp_pkg::OP_EEPROM_RD) begin
                           r_kind = 1'b1; r_rd = {8'd0, a_reply};
                        end else if (op_ff == aisp_pkg::OP_FLASH_RD) begin
                           low_in = a_reply; phase_in = aisp_pkg::PH_MAIN2; r_byte = 1'b1;
                        end else if (op_ff <= aisp_pkg::OP_FUSEX_WR) begin
                           phase_in = aisp_pkg::PH_POLL_EN; r_byte = 1'b1;
                        end else if (op_ff == aisp_pkg::OP_FLASH_LD) begin
                           phase_in = aisp_pkg::PH_MAIN2; r_byte = 1'b1;
                        end else if (due_ff) begin
                           phase_in = aisp_pkg::PH_PAGE; r_byte = 1'b1;
                        end else r_kind = 1'b1;
                     aisp_pkg::PH_MAIN2:
                        if (op_ff == aisp_pkg::OP_FLASH_RD) begin
                           r_kind = 1'b1; r_rd = {a_reply, low_ff};
                        end else if (due_ff) begin
                           phase_in = aisp_pkg::PH_PAGE; r_byte = 1'b1;
                        end else r_kind = 1'b1;
                     aisp_pkg::PH_PAGE: begin
                        phase_in = aisp_pkg::PH_POLL_EN; r_byte = 1'b1;
                     end
                     aisp_pkg::PH_POLL_EN:
                        if (echo_ff != aisp_pkg::CMD_ECHO) begin
                           r_kind = 1'b1; r_st = aisp_pkg::ST_NO_ECHO;
                        end else begin phase_in = aisp_pkg::PH_POLL; r_byte = 1'b1; end
                     default:
                        if (a_reply[0]) begin
                           phase_in = aisp_pkg::PH_POLL_EN; r_byte = 1'b1;
                        end else r_kind = 1'b1;
                  endcase
               end
            end
            if (r_kind) begin
               phase_in = aisp_pkg::PH_IDLE; pos_in = 2'd0;
            end
         end
      end
   end

   logic [32:0] r_word;
   assign r_word = r_byte ? {1'b0, 6'd0, 2'd0, 16'd0, tx_byte}
                          : {1'b1, 6'd0, r_st, r_rd, 8'd0};

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= aisp_pkg::PH_IDLE; pos_ff <= 2'd0; op_ff <= 4'd0;
         addr_ff <= 16'd0; data_ff <= 16'd0; low_ff <= 8'd0; echo_ff <= 8'd0;
         due_ff <= 1'b0; log2_ff <= aisp_pkg::FlashPageLog2Reset;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; op_ff <= op_in;
         addr_ff <= addr_in; data_ff <= data_in; low_ff <= low_in;
         echo_ff <= echo_in; due_ff <= due_in;
         if (csr_wr_en) log2_ff <= csr_wr_data;
      end
   end

   // Output register with skid entry.
   logic out_take;
   assign out_take = rsp_tvalid && rsp_tready;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0; skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff || out_take) begin
            if (skid_v_ff) begin
               out_v_ff <= 1'b1; out_d_ff <= skid_d_ff; skid_v_ff <= 1'b0;
            end else begin
               out_v_ff <= r_v; out_d_ff <= r_word;
            end
         end else if (r_v) begin
            skid_v_ff <= 1'b1; skid_d_ff <= r_word;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_d_ff[32];
   assign rsp_tdata  = out_d_ff[31:0];

   a_skid_only_when_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid holds data while output empty");
   a_idle_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == aisp_pkg::PH_IDLE |-> pos_ff == 2'd0) else $error("idle with position");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (r_v && r_kind) |=> phase_ff == aisp_pkg::PH_IDLE) else $error("completion not idle");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> out_v_ff) else $error("response dropped");

endmodule

// File: bench/tb_avr_isp_command_engine_core.sv
// Testbench for the AVR serial programming command engine.
// Drives commands and reply bytes, predicts every response and checks it.
// Depends on aisp_pkg and avr_isp_command_engine_core.
`timescale 1ns / 100ps

// Item that goes into the block as one transaction.
typedef struct {
   bit          action;
   logic [3:0]  op;
   logic [15:0] addr;
   logic [15:0] wdata;
   bit          last;
   bit          send_en;
   logic [7:0]  reply;
   bit          reply_err;
} isp_req_type;

// Item that comes out of the block as one transaction.
typedef struct {
   bit          kind;
   logic [7:0]  tx_byte;
   logic [15:0] rd_data;
   logic [1:0]  status;
} isp_rsp_type;

class isp_scoreboard;
   aisp_pkg::phase_type phase;
   logic [1:0]  pos;
   logic [3:0]  h_op;
   logic [15:0] h_addr;
   logic [15:0] h_data;
   logic [7:0]  low_rd;
   logic [7:0]  echo;
   bit          page_due;
   logic [2:0]  page_log2;
   isp_rsp_type pending[$];
   int          errors;
   int          completions;

   function new();
      phase = aisp_pkg::PH_IDLE;
      pos = 2'd0;
      h_op = 4'd0;
      h_addr = 16'd0;
      h_data = 16'd0;
      low_rd = 8'd0;
      echo = 8'd0;
      page_due = 0;
      page_log2 = aisp_pkg::FlashPageLog2Reset;
      errors = 0;
      completions = 0;
   endfunction

   function bit is_enable_frame();
      return phase == aisp_pkg::PH_PRE_EN || phase == aisp_pkg::PH_POLL_EN ||
             (phase == aisp_pkg::PH_MAIN && h_op == aisp_pkg::OP_ENABLE);
   endfunction

   // Byte of the current instruction frame at position p.
   function logic [7:0] frame_byte(logic [1:0] p);
      logic [7:0] f[4];
      logic [7:0] ah;
      logic [7:0] al;
      logic [7:0] dl;
      logic [15:0] ee_off;
      ah = h_addr[15:8];
      al = h_addr[7:0];
      dl = h_data[7:0];
      ee_off = 16'(h_addr % aisp_pkg::EepromPageBytes);
      f[0] = 8'd0; f[1] = 8'd0; f[2] = 8'd0; f[3] = 8'd0;
      if (is_enable_frame()) begin
         f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::CMD_ECHO;
      end else if (phase == aisp_pkg::PH_POLL) begin
         f[0] = aisp_pkg::CMD_POLL;
      end else if (phase == aisp_pkg::PH_PAGE) begin
         if (h_op == aisp_pkg::OP_FLASH_LD) begin
            f[0] = aisp_pkg::CMD_WR_FLPG; f[1] = ah; f[2] = al;
         end else begin
            f[0] = aisp_pkg::CMD_WR_EEPG; f[1] = {6'd0, ah[1:0]};
            f[2] = 8'(h_addr - ee_off);
         end
      end else if (phase == aisp_pkg::PH_MAIN2) begin
         if (h_op == aisp_pkg::OP_FLASH_RD) begin
            f[0] = aisp_pkg::CMD_RD_FLH; f[1] = ah; f[2] = al;
         end else begin
            f[0] = aisp_pkg::CMD_LD_FLH; f[2] = al; f[3] = h_data[15:8];
         end
      end else begin
         case (h_op)
            aisp_pkg::OP_SIGNATURE: begin f[0] = aisp_pkg::CMD_SIG; f[2] = al; end
            aisp_pkg::OP_LOCK_RD:   f[0] = aisp_pkg::CMD_RD_LOCK;
            aisp_pkg::OP_FUSE_RD:   f[0] = aisp_pkg::CMD_RD_FUSE;
            aisp_pkg::OP_FUSEH_RD:  begin f[0] = aisp_pkg::CMD_RD_LOCK; f[1] = 8'h08; end
            aisp_pkg::OP_FUSEX_RD:  begin f[0] = aisp_pkg::CMD_RD_FUSE; f[1] = 8'h08; end
            aisp_pkg::OP_CALIB_RD:  f[0] = aisp_pkg::CMD_RD_CAL;
            aisp_pkg::OP_FLASH_RD: begin
               f[0] = aisp_pkg::CMD_RD_FLL; f[1] = ah; f[2] = al;
            end
            aisp_pkg::OP_EEPROM_RD: begin
               f[0] = aisp_pkg::CMD_RD_EE; f[1] = {6'd0, ah[1:0]}; f[2] = al;
            end
            aisp_pkg::OP_ERASE: begin
               f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::SUB_ERASE;
            end
            aisp_pkg::OP_LOCK_WR: begin
               f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::SUB_WR_LOCK; f[3] = dl;
            end
            aisp_pkg::OP_FUSE_WR: begin
               f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::SUB_WR_FUSE; f[3] = dl;
            end
            aisp_pkg::OP_FUSEH_WR: begin
               f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::SUB_WR_FUSEH; f[3] = dl;
            end
            aisp_pkg::OP_FUSEX_WR: begin
               f[0] = aisp_pkg::CMD_PROG_EN; f[1] = aisp_pkg::SUB_WR_FUSEX; f[3] = dl;
            end
            aisp_pkg::OP_FLASH_LD: begin
               f[0] = aisp_pkg::CMD_LD_FLL; f[2] = al; f[3] = dl;
            end
            default: begin
               f[0] = aisp_pkg::CMD_LD_EE; f[2] = ee_off[7:0]; f[3] = dl;
            end
         endcase
      end
      return f[p];
   endfunction

   function void push_byte();
      isp_rsp_type r;
      r.kind = 0; r.tx_byte = frame_byte(pos); r.rd_data = 16'd0;
      r.status = aisp_pkg::ST_OK;
      pending.push_back(r);
   endfunction

   function void push_done(logic [15:0] d, logic [1:0] st);
      isp_rsp_type r;
      phase = aisp_pkg::PH_IDLE;
      pos = 2'd0;
      r.kind = 1; r.tx_byte = 8'd0; r.rd_data = d; r.status = st;
      pending.push_back(r);
      completions++;
   endfunction

   function void begin_frame(aisp_pkg::phase_type ph);
      phase = ph;
      pos = 2'd0;
      push_byte();
   endfunction

   // Note an accepted request and queue the response it causes.
   function void note_request(isp_req_type q);
      logic [16:0] nxt;
      logic [16:0] mask;
      if (!q.action) begin
         if (phase != aisp_pkg::PH_IDLE) return;
         h_op = q.op; h_addr = q.addr; h_data = q.wdata;
         low_rd = 8'd0; echo = 8'd0;
         nxt = {1'b0, h_addr} + 17'd1;
         mask = (17'd1 << page_log2) - 17'd1;
         if (h_op == aisp_pkg::OP_FLASH_LD)
            page_due = q.last || ((nxt & mask) == 17'd0);
         else if (h_op == aisp_pkg::OP_EEPROM_LD)
            page_due = q.last || (nxt % aisp_pkg::EepromPageBytes == 0);
         else page_due = 0;
         if (q.send_en && h_op != aisp_pkg::OP_ENABLE) begin_frame(aisp_pkg::PH_PRE_EN);
         else begin_frame(aisp_pkg::PH_MAIN);
         return;
      end
      if (phase == aisp_pkg::PH_IDLE) return;
      if (q.reply_err) begin
         push_done(16'd0, aisp_pkg::ST_LINK_ERR);
         return;
      end
      if (pos == 2'd2 && is_enable_frame()) echo = q.reply;
      if (pos < 2'd3) begin
         pos++;
         push_byte();
         return;
      end
      case (phase)
         aisp_pkg::PH_PRE_EN: begin
            if (echo != aisp_pkg::CMD_ECHO) push_done(16'd0, aisp_pkg::ST_NO_ECHO);
            else begin_frame(aisp_pkg::PH_MAIN);
         end
         aisp_pkg::PH_MAIN: begin
            if (h_op == aisp_pkg::OP_ENABLE)
               push_done(16'd0, echo == aisp_pkg::CMD_ECHO ?
                                aisp_pkg::ST_OK : aisp_pkg::ST_NO_ECHO);
            else if (h_op <= aisp_pkg::OP_CALIB_RD || h_op == aisp_pkg::OP_EEPROM_RD)
               push_done({8'd0, q.reply}, aisp_pkg::ST_OK);
            else if (h_op == aisp_pkg::OP_FLASH_RD) begin
               low_rd = q.reply;
               begin_frame(aisp_pkg::PH_MAIN2);
            end else if (h_op <= aisp_pkg::OP_FUSEX_WR) begin_frame(aisp_pkg::PH_POLL_EN);
            else if (h_op == aisp_pkg::OP_FLASH_LD) begin_frame(aisp_pkg::PH_MAIN2);
            else if (page_due) begin_frame(aisp_pkg::PH_PAGE);
            else push_done(16'd0, aisp_pkg::ST_OK);
         end
         aisp_pkg::PH_MAIN2: begin
            if (h_op == aisp_pkg::OP_FLASH_RD) push_done({q.reply, low_rd}, aisp_pkg::ST_OK);
            else if (page_due) begin_frame(aisp_pkg::PH_PAGE);
            else push_done(16'd0, aisp_pkg::ST_OK);
         end
         aisp_pkg::PH_PAGE: begin_frame(aisp_pkg::PH_POLL_EN);
         aisp_pkg::PH_POLL_EN: begin
            if (echo != aisp_pkg::CMD_ECHO) push_done(16'd0, aisp_pkg::ST_NO_ECHO);
            else begin_frame(aisp_pkg::PH_POLL);
         end
         default: begin
            if (q.reply[0]) begin_frame(aisp_pkg::PH_POLL_EN);
            else push_done(16'd0, aisp_pkg::ST_OK);
         end
      endcase
   endfunction

   // Compare a response with the oldest expectation.
   function void check_response(isp_rsp_type a);
      isp_rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response kind=%0d tx=%h data=%h st=%0d",
                  $time, a.kind, a.tx_byte, a.rd_data, a.status);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (e.kind !== a.kind || e.tx_byte !== a.tx_byte ||
          e.rd_data !== a.rd_data || e.status !== a.status) begin
         $display("%0t: mismatch expected kind=%0d tx=%h data=%h st=%0d,",
                  $time, e.kind, e.tx_byte, e.rd_data, e.status);
         $display("   actual kind=%0d tx=%h data=%h st=%0d",
                  a.kind, a.tx_byte, a.rd_data, a.status);
         errors++;
      end
   endfunction
endclass

module tb_avr_isp_command_engine_core;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [2:0]  csr_wr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   isp_scoreboard sb = new();
   int  idle_pct = 34;
   int  items_sent = 0;

   avr_isp_command_engine_core dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // Receiver side: random stalls, every response transaction checked.
   always @(posedge clock) begin
      isp_rsp_type r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         r.kind = rsp_tuser; r.tx_byte = rsp_tdata[7:0];
         r.rd_data = rsp_tdata[23:8]; r.status = rsp_tdata[25:24];
         sb.check_response(r);
      end
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // Send one request transaction, with a random gap beforehand. Valid stays
   // high after acceptance so the next transaction can follow back to back.
   task automatic send(isp_req_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= q.action;
      req_tdata <= {2'b00, q.reply_err, q.reply, q.send_en, q.wdata, q.addr, q.op};
      req_tlast <= q.last;
      do @(posedge clock); while (!req_tready);
      sb.note_request(q);
      items_sent++;
   endtask

   task automatic command(logic [3:0] op, logic [15:0] addr, logic [15:0] wd,
                          bit last, bit send_en);
      isp_req_type q;
      q.action = 0; q.op = op; q.addr = addr; q.wdata = wd; q.last = last;
      q.send_en = send_en; q.reply = 8'($urandom); q.reply_err = 0;
      send(q);
   endtask

   task automatic reply(logic [7:0] b, bit err);
      isp_req_type q;
      q.action = 1; q.op = 4'($urandom); q.addr = 16'($urandom);
      q.wdata = 16'($urandom); q.last = 1'($urandom); q.send_en = 1'($urandom);
      q.reply = b; q.reply_err = err;
      send(q);
   endtask

   // Answer until idle (200 replies at most); echoes bad at bad_echo_pct, polls mostly ready.
   task automatic converse(int err_pct, int bad_echo_pct);
      logic [7:0] b;
      int guard;
      guard = 0;
      while (sb.phase != aisp_pkg::PH_IDLE && guard < 200) begin
         b = 8'($urandom);
         if (sb.pos == 2'd2 && sb.is_enable_frame() && $urandom_range(99) >= bad_echo_pct)
            b = aisp_pkg::CMD_ECHO;
         if (sb.phase == aisp_pkg::PH_POLL && sb.pos == 2'd3 && $urandom_range(99) < 60)
            b[0] = 1'b0;
         reply(b, $urandom_range(99) < err_pct);
         guard++;
      end
   endtask

   // Stop sending and wait until every expected response has come.
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_page_log2(logic [2:0] v);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.page_log2 = v;
   endtask

   initial begin
      int k;
      logic [3:0] op;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: every operation, address and data extremes, clean replies.
      for (k = 0; k < 16; k++) begin
         command(k[3:0], (k % 2 != 0) ? 16'hFFFF : 16'h0000,
                 (k % 2 != 0) ? 16'h0000 : 16'hFFFF, k % 3 == 0, k % 2 != 0);
         converse(0, 0);
      end
      // Missing echo, link error, reply while idle, command while busy.
      command(aisp_pkg::OP_LOCK_RD, 16'd0, 16'd0, 1'b0, 1'b1);
      converse(0, 100);
      command(aisp_pkg::OP_FLASH_RD, 16'h1234, 16'd0, 1'b0, 1'b0);
      reply(8'h00, 1'b0);
      command(aisp_pkg::OP_ERASE, 16'd0, 16'd0, 1'b0, 1'b0);
      reply(8'hFF, 1'b1);
      reply(8'hAA, 1'b0);
      command(aisp_pkg::OP_EEPROM_LD, 16'h0303, 16'h00A5, 1'b0, 1'b1);
      converse(0, 0);

      // Sender holds off until every expected response is in.
      drain();

      // Random phases, each with its own flash page size; extremes included.
      for (int ph = 0; ph < 6; ph++) begin
         write_page_log2(ph == 0 ? 3'd0 : ph == 1 ? 3'd7 : 3'($urandom));
         idle_pct = (ph == 3) ? 0 : 34;
         for (k = 0; k < 8; k++) begin
            op = 4'($urandom);
            if ($urandom_range(99) < 40) op = 4'($urandom_range(14, 15));
            command(op, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20)),
                    16'($urandom), $urandom_range(99) < 20, 1'($urandom));
            if ($urandom_range(99) < 10)
               command(4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                       1'($urandom));
            converse(3, 5);
         end
      end
      write_page_log2(aisp_pkg::FlashPageLog2Reset);

      drain();
      $display("Sent %0d transactions; %0d operations completed across page sizes 1 to 128 words.",
               items_sent, sb.completions);
      $display("Covered all sixteen operations, echo failures, link errors and ready polling.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

// File: filelist.f
rtl/aisp_pkg.sv
rtl/aisp_frame.sv
rtl/avr_isp_command_engine_core.sv
bench/tb_avr_isp_command_engine_core.sv
